// File: design/kubf_pkg.sv
// Shared types and constants of the k-mer first-occurrence bitmap filter.
package kubf_pkg;

   // operation codes of an input beat
   localparam logic OP_SYMBOL = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   // result kinds
   localparam logic KIND_NEW   = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // register indexes
   localparam logic CSR_WORD_LENGTH = 1'b0;
   localparam logic CSR_MASK_LOWER  = 1'b1;

   localparam int CsrDataW = 4;
   localparam int KmerW    = 16;
   localparam int CountW   = 17;
   localparam int SeenW    = 4;
   localparam int EpochW   = 4;

   localparam logic [CountW-1:0] CountMax = 17'd65536;
   localparam logic [SeenW-1:0]  SeenMax  = 4'd15;
   localparam logic [EpochW-1:0] EpochMax = 4'd15;
   localparam logic [EpochW-1:0] EpochFirst = 4'd1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK
   } kubf_state_type;

   typedef struct packed {
      logic accept;
      logic sweep;
      logic finish;
   } kubf_cmd_type;

   typedef struct packed {
      logic wrap;
      logic sweep_done;
      logic out_free;
      logic emit;
   } kubf_status_type;

endpackage

// File: design/kubf_ctrl.sv
// Controller state machine: bitmap clearing pass, beat intake and lookup sequencing.
module kubf_ctrl
   import kubf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  kubf_status_type status,
   output kubf_cmd_type    cmd
);

   kubf_state_type state_ff, state_in;
   logic           pend_ff, pend_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      pend_in    = pend_ff;
      req_ready  = 1'b0;
      cmd.accept = 1'b0;
      cmd.sweep  = 1'b0;
      cmd.finish = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.sweep = 1'b1;
            if (status.sweep_done) begin
               state_in = pend_ff ? ST_LOOK : ST_IDLE;
               pend_in  = 1'b0;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.wrap) begin
                  state_in = ST_CLEAR;
                  pend_in  = 1'b1;
               end else begin
                  state_in = ST_LOOK;
               end
            end
         end
         ST_LOOK: begin
            if (status.out_free || !status.emit) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

// File: design/kubf_datapath.sv
// Datapath: windows, counters, epoch-tagged seen bitmap and result register.
module kubf_datapath
   import kubf_pkg::*;
#(
   parameter int MAX_WORD = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  kubf_cmd_type         cmd,
   output kubf_status_type      status,
   input  logic                 csr_write_enable,
   input  logic                 csr_index,
   input  logic [CsrDataW-1:0]  csr_write_data,
   input  logic                 req_operation,
   input  logic                 req_start_req,
   input  logic [1:0]           req_base_code,
   input  logic                 req_is_ambiguous,
   input  logic                 req_is_lowercase,
   input  logic [KmerW-1:0]     req_query_kmer,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_result_kind,
   output logic [KmerW-1:0]     rsp_kmer_value,
   output logic [KmerW-1:0]     rsp_unique_index,
   output logic                 rsp_hit,
   output logic [CountW-1:0]    rsp_shared_total
);

   localparam int MapAw    = 2 * MAX_WORD;
   localparam int MapDepth = 1 << MapAw;

   // configuration
   logic [3:0] word_length_ff;
   logic       mask_lower_ff;

   // sequence state
   logic [MapAw-1:0]  kmer_win_ff, bad_win_ff;
   logic [SeenW-1:0]  seen_ff;
   logic [CountW-1:0] unique_ff, hit_cnt_ff;
   logic [EpochW-1:0] epoch_ff;
   logic [MapAw-1:0]  sweep_addr_ff;

   // latched beat
   logic              op_ff, start_ff, cand_ff;
   logic [MapAw-1:0]  addr_ff;
   logic [KmerW-1:0]  query_ff;

   // bitmap
   logic [EpochW-1:0] mem [MapDepth];
   logic [EpochW-1:0] rd_ff;

   // result register
   logic              rsp_valid_ff, kind_ff, hit_ff;
   logic [KmerW-1:0]  kmer_ff, index_ff;
   logic [CountW-1:0] total_ff;

   logic [3:0]        k_eff;
   logic [MapAw-1:0]  win_mask;
   logic              seq_start, bad;
   logic [MapAw-1:0]  kw_base, bw_base, kw_next, bw_next;
   logic [SeenW-1:0]  seen_base, seen_next;
   logic [MapAw+KmerW-1:0] q_ext, k_ext;
   logic [MapAw-1:0]  q_idx, rd_addr;
   logic              hit, emit, mem_we;
   logic [MapAw-1:0]  mem_waddr;
   logic [EpochW-1:0] mem_wdata;
   logic [CountW-1:0] hit_cnt_next, unique_next;

   always_comb begin
      if (word_length_ff == 4'd0) begin
         k_eff = 4'd1;
      end else if (word_length_ff > 4'(MAX_WORD)) begin
         k_eff = 4'(MAX_WORD);
      end else begin
         k_eff = word_length_ff;
      end
   end

   assign win_mask  = ~({MapAw{1'b1}} << {k_eff, 1'b0});
   assign seq_start = (req_operation == OP_SYMBOL) && req_start_req;
   assign bad       = req_is_ambiguous | (req_is_lowercase & mask_lower_ff);
   assign kw_base   = seq_start ? '0 : kmer_win_ff;
   assign bw_base   = seq_start ? '0 : bad_win_ff;
   assign seen_base = seq_start ? '0 : seen_ff;
   assign kw_next   = ((kw_base << 2) | MapAw'(req_base_code)) & win_mask;
   assign bw_next   = ((bw_base << 2) | MapAw'({2{bad}})) & win_mask;
   assign seen_next = (seen_base == SeenMax) ? SeenMax : seen_base + 4'd1;
   assign q_ext     = {{MapAw{1'b0}}, req_query_kmer};
   assign q_idx     = q_ext[MapAw-1:0] & win_mask;
   assign rd_addr   = (req_operation == OP_QUERY) ? q_idx : kw_next;
   assign k_ext     = {{KmerW{1'b0}}, addr_ff};

   assign hit  = !((op_ff == OP_SYMBOL) && start_ff) && (rd_ff == epoch_ff);
   assign emit = (op_ff == OP_QUERY) || (cand_ff && !hit);

   assign hit_cnt_next = (hit && hit_cnt_ff != CountMax) ? hit_cnt_ff + 17'd1 : hit_cnt_ff;
   assign unique_next  = (unique_ff != CountMax) ? unique_ff + 17'd1 : unique_ff;

   assign mem_we    = cmd.sweep || (cmd.finish && emit && op_ff == OP_SYMBOL);
   assign mem_waddr = cmd.sweep ? sweep_addr_ff : addr_ff;
   assign mem_wdata = cmd.sweep ? '0 : epoch_ff;

   assign status.wrap       = seq_start && (epoch_ff == EpochMax);
   assign status.sweep_done = (sweep_addr_ff == {MapAw{1'b1}});
   assign status.out_free   = !rsp_valid_ff || rsp_ready;
   assign status.emit       = emit;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.accept) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_length_ff <= 4'd8;
         mask_lower_ff  <= 1'b0;
         kmer_win_ff    <= '0;
         bad_win_ff     <= '0;
         seen_ff        <= '0;
         unique_ff      <= '0;
         hit_cnt_ff     <= '0;
         epoch_ff       <= EpochFirst;
         sweep_addr_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_WORD_LENGTH: word_length_ff <= csr_write_data;
               CSR_MASK_LOWER:  mask_lower_ff  <= csr_write_data[0];
               default: ;
            endcase
         end
         if (cmd.sweep) begin
            sweep_addr_ff <= sweep_addr_ff + MapAw'(1);
            if (status.sweep_done) begin
               epoch_ff <= EpochFirst;
            end
         end
         if (cmd.accept) begin
            if (req_operation == OP_SYMBOL) begin
               kmer_win_ff <= kw_next;
               bad_win_ff  <= bw_next;
               seen_ff     <= seen_next;
            end
            if (req_start_req) begin
               hit_cnt_ff <= '0;
            end
            if (seq_start) begin
               unique_ff <= '0;
               if (epoch_ff != EpochMax) begin
                  epoch_ff <= epoch_ff + 4'd1;
               end
            end
         end
         if (cmd.finish) begin
            if (op_ff == OP_QUERY) begin
               hit_cnt_ff <= hit_cnt_next;
            end else if (emit) begin
               unique_ff <= unique_next;
            end
         end
         if (cmd.finish && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // latch beat and load result payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= req_operation;
         start_ff <= req_start_req;
         addr_ff  <= rd_addr;
         query_ff <= req_query_kmer;
         cand_ff  <= (req_operation == OP_SYMBOL) && (seen_next >= k_eff) && (bw_next == '0);
      end
      if (cmd.finish && emit) begin
         if (op_ff == OP_QUERY) begin
            kind_ff  <= KIND_QUERY;
            kmer_ff  <= query_ff;
            index_ff <= '0;
            hit_ff   <= hit;
            total_ff <= hit_cnt_next;
         end else begin
            kind_ff  <= KIND_NEW;
            kmer_ff  <= k_ext[KmerW-1:0];
            index_ff <= unique_ff[KmerW-1:0];
            hit_ff   <= 1'b0;
            total_ff <= '0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = kind_ff;
   assign rsp_kmer_value   = kmer_ff;
   assign rsp_unique_index = index_ff;
   assign rsp_hit          = hit_ff;
   assign rsp_shared_total = total_ff;

endmodule

// File: design/kmer_unique_bitmap_filter.sv
// Top level of the k-mer first-occurrence bitmap filter.
//
//   chan | dir | handshake           | payload
//   req  | in  | req_valid/req_ready | operation, start_req, base_code, flags, query_kmer
//   rsp  | out | rsp_valid/rsp_ready | result_kind, kmer_value, unique_index, hit, shared_total
//   csr  | in  | csr_write_enable    | csr_index, csr_write_data
//
// Each beat passes through intake with the bitmap read, then lookup and, for a new k-mer, the bitmap write.
// After reset a clearing pass over all 4**MAX_WORD bitmap entries runs before the first beat is taken.
// Sequence starts advance a 4-bit epoch tag; every fifteenth start reruns the clearing pass.
// A held result register stalls the lookup of a beat that yields a result until rsp_ready frees it.
module kmer_unique_bitmap_filter
   import kubf_pkg::*;
#(
   parameter int MAX_WORD = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic                csr_index,
   input  logic [CsrDataW-1:0] csr_write_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_operation,
   input  logic                req_start_req,
   input  logic [1:0]          req_base_code,
   input  logic                req_is_ambiguous,
   input  logic                req_is_lowercase,
   input  logic [KmerW-1:0]    req_query_kmer,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_result_kind,
   output logic [KmerW-1:0]    rsp_kmer_value,
   output logic [KmerW-1:0]    rsp_unique_index,
   output logic                rsp_hit,
   output logic [CountW-1:0]   rsp_shared_total
);

   kubf_cmd_type    cmd;
   kubf_status_type status;

   kubf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   kubf_datapath #(
      .MAX_WORD (MAX_WORD)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_operation    (req_operation),
      .req_start_req    (req_start_req),
      .req_base_code    (req_base_code),
      .req_is_ambiguous (req_is_ambiguous),
      .req_is_lowercase (req_is_lowercase),
      .req_query_kmer   (req_query_kmer),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_kmer_value   (rsp_kmer_value),
      .rsp_unique_index (rsp_unique_index),
      .rsp_hit          (rsp_hit),
      .rsp_shared_total (rsp_shared_total)
   );

endmodule

// File: tb/sv/kubf_checker.sv
`timescale 1ns / 1ps
// Scoreboard of the k-mer filter testbench: predicts each result beat and compares it.
module kubf_checker
   import kubf_pkg::*;
#(
   parameter int MAX_WORD = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic                csr_index,
   input  logic [CsrDataW-1:0] csr_write_data,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic                req_operation,
   input  logic                req_start_req,
   input  logic [1:0]          req_base_code,
   input  logic                req_is_ambiguous,
   input  logic                req_is_lowercase,
   input  logic [KmerW-1:0]    req_query_kmer,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic                rsp_result_kind,
   input  logic [KmerW-1:0]    rsp_kmer_value,
   input  logic [KmerW-1:0]    rsp_unique_index,
   input  logic                rsp_hit,
   input  logic [CountW-1:0]   rsp_shared_total,
   output int                  fail_count,
   output int                  answers_outstanding,
   output int                  results_checked
);

   typedef struct packed {
      logic              kind;
      logic [KmerW-1:0]  kmer;
      logic [KmerW-1:0]  index;
      logic              hit;
      logic [CountW-1:0] total;
   } filter_answer_type;

   filter_answer_type answers_due [$];

   logic [3:0]        word_length_reg;
   logic              mask_lower_reg;
   logic [KmerW-1:0]  kmer_window;
   logic [KmerW-1:0]  bad_window;
   logic [SeenW-1:0]  symbols_taken;
   logic [CountW-1:0] new_kmer_count;
   logic [CountW-1:0] hit_count;
   // a k-mer is in the map when its tag equals the current sequence tag
   int unsigned       map_tag [0:(1 << KmerW)-1];
   int unsigned       sequence_tag = 1;

   function automatic int unsigned word_k();
      if (word_length_reg == 4'd0) return 1;
      if (word_length_reg > MAX_WORD) return MAX_WORD;
      return word_length_reg;
   endfunction

   task automatic report_mismatch(input string msg);
      if (fail_count < 100) $display("%0t ns mismatch: %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [CountW-1:0] got,
                              input logic [CountW-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s is %0h, expected %0h",
                                   results_checked, name, got, want));
   endtask

   task automatic check_answer();
      filter_answer_type want;
      if (answers_due.size() == 0) begin
         report_mismatch($sformatf("result beat with kmer_value %0h while none is due",
                                   rsp_kmer_value));
      end else begin
         want = answers_due.pop_front();
         check_field("result_kind", CountW'(rsp_result_kind), CountW'(want.kind));
         check_field("kmer_value", CountW'(rsp_kmer_value), CountW'(want.kmer));
         check_field("unique_index", CountW'(rsp_unique_index), CountW'(want.index));
         check_field("hit", CountW'(rsp_hit), CountW'(want.hit));
         check_field("shared_total", rsp_shared_total, want.total);
      end
      results_checked++;
   endtask

   task automatic filter_beat();
      int unsigned       k;
      logic [31:0]       wide_mask;
      logic [KmerW-1:0]  m;
      logic              found;
      logic              bad;
      filter_answer_type ans;
      k = word_k();
      wide_mask = (32'd1 << (2 * k)) - 32'd1;
      m = wide_mask[KmerW-1:0];
      if (req_operation == OP_QUERY) begin
         if (req_start_req) hit_count = '0;
         found = (map_tag[req_query_kmer & m] == sequence_tag);
         if (found && hit_count < CountMax) hit_count = hit_count + 17'd1;
         ans = '{kind: KIND_QUERY, kmer: req_query_kmer, index: '0, hit: found,
                 total: hit_count};
         answers_due.push_back(ans);
      end else begin
         if (req_start_req) begin
            sequence_tag++;
            kmer_window = '0;
            bad_window = '0;
            symbols_taken = '0;
            new_kmer_count = '0;
            hit_count = '0;
         end
         bad = req_is_ambiguous | (req_is_lowercase & mask_lower_reg);
         bad_window = ((bad_window << 2) | KmerW'({2{bad}})) & m;
         kmer_window = ((kmer_window << 2) | KmerW'(req_base_code)) & m;
         if (symbols_taken < SeenMax) symbols_taken = symbols_taken + 4'd1;
         if (symbols_taken >= k && bad_window == '0 && map_tag[kmer_window] != sequence_tag)
         begin
            map_tag[kmer_window] = sequence_tag;
            ans = '{kind: KIND_NEW, kmer: kmer_window, index: new_kmer_count[KmerW-1:0],
                    hit: 1'b0, total: '0};
            answers_due.push_back(ans);
            if (new_kmer_count < CountMax) new_kmer_count = new_kmer_count + 17'd1;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         word_length_reg = 4'd8;
         mask_lower_reg = 1'b0;
         kmer_window = '0;
         bad_window = '0;
         symbols_taken = '0;
         new_kmer_count = '0;
         hit_count = '0;
         sequence_tag++;
         answers_due.delete();
         fail_count = 0;
         results_checked = 0;
         answers_outstanding <= 0;
      end else begin
         if (rsp_valid && rsp_ready) check_answer();
         if (csr_write_enable) begin
            if (csr_index == CSR_WORD_LENGTH) word_length_reg = csr_write_data[3:0];
            else mask_lower_reg = csr_write_data[0];
         end
         if (req_valid && req_ready) filter_beat();
         answers_outstanding <= answers_due.size();
      end
   end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the k-mer filter testbench: clock, reset, stimulus and verdict.
module tb_top;
   import kubf_pkg::*;

   localparam int MAX_WORD = 8;
   localparam int CycleLimit = 3_000_000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_write_enable = 1'b0;
   logic                csr_index = CSR_WORD_LENGTH;
   logic [CsrDataW-1:0] csr_write_data = '0;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_operation = OP_SYMBOL;
   logic                req_start_req = 1'b0;
   logic [1:0]          req_base_code = '0;
   logic                req_is_ambiguous = 1'b0;
   logic                req_is_lowercase = 1'b0;
   logic [KmerW-1:0]    req_query_kmer = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_result_kind;
   logic [KmerW-1:0]    rsp_kmer_value;
   logic [KmerW-1:0]    rsp_unique_index;
   logic                rsp_hit;
   logic [CountW-1:0]   rsp_shared_total;

   int               fail_count;
   int               answers_outstanding;
   int               results_checked;
   int               cycle_count = 0;
   int               beats_sent = 0;
   int               sequence_starts = 0;
   int               settings_used = 0;
   logic             sender_gaps = 1'b1;
   logic             receiver_stalls = 1'b1;
   logic [KmerW-1:0] recent_bases = '0;
   int               run_left = 0;
   logic             run_noisy = 1'b0;
   logic             run_lower = 1'b0;

   kmer_unique_bitmap_filter #(.MAX_WORD(MAX_WORD)) i_dut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_start_req(req_start_req),
      .req_base_code(req_base_code),
      .req_is_ambiguous(req_is_ambiguous),
      .req_is_lowercase(req_is_lowercase),
      .req_query_kmer(req_query_kmer),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_result_kind(rsp_result_kind),
      .rsp_kmer_value(rsp_kmer_value),
      .rsp_unique_index(rsp_unique_index),
      .rsp_hit(rsp_hit),
      .rsp_shared_total(rsp_shared_total)
   );

   kubf_checker #(.MAX_WORD(MAX_WORD)) i_checker (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_start_req(req_start_req),
      .req_base_code(req_base_code),
      .req_is_ambiguous(req_is_ambiguous),
      .req_is_lowercase(req_is_lowercase),
      .req_query_kmer(req_query_kmer),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_result_kind(rsp_result_kind),
      .rsp_kmer_value(rsp_kmer_value),
      .rsp_unique_index(rsp_unique_index),
      .rsp_hit(rsp_hit),
      .rsp_shared_total(rsp_shared_total),
      .fail_count(fail_count),
      .answers_outstanding(answers_outstanding),
      .results_checked(results_checked)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= !receiver_stalls || ($urandom_range(99) >= 19);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, answers_outstanding);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_beat(input logic op, input logic start, input logic [1:0] base,
                            input logic ambiguous, input logic lower,
                            input logic [KmerW-1:0] kmer);
      if (sender_gaps) begin
         while ($urandom_range(99) < 19) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_start_req <= start;
      req_base_code <= base;
      req_is_ambiguous <= ambiguous;
      req_is_lowercase <= lower;
      req_query_kmer <= kmer;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
      if (op == OP_SYMBOL) begin
         recent_bases = {recent_bases[KmerW-3:0], base};
         if (start) sequence_starts++;
      end
   endtask

   task automatic send_symbol(input logic start, input logic [1:0] base,
                              input logic ambiguous, input logic lower);
      logic [KmerW-1:0] junk;
      junk = KmerW'($urandom_range(16'hFFFF));
      send_beat(OP_SYMBOL, start, base, ambiguous, lower, junk);
   endtask

   task automatic send_query(input logic start, input logic [KmerW-1:0] kmer);
      send_beat(OP_QUERY, start, 2'($urandom_range(3)), 1'($urandom_range(1)),
                1'($urandom_range(1)), kmer);
   endtask

   task automatic random_symbol(input logic start);
      logic ambiguous;
      logic lower;
      ambiguous = run_noisy ? ($urandom_range(99) < 40) : ($urandom_range(99) < 5);
      lower = run_lower ? ($urandom_range(3) != 0) : ($urandom_range(99) < 5);
      send_symbol(start, 2'($urandom_range(3)), ambiguous, lower);
   endtask

   // flush with a query beat, hold valid low and wait for every result
   task automatic settle();
      send_query(1'($urandom_range(1)), KmerW'($urandom_range(16'hFFFF)));
      req_valid <= 1'b0;
      @(posedge clock);
      while (answers_outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_config(input logic [3:0] word_length, input logic mask_lower);
      logic [CsrDataW-1:0] noise;
      noise = CsrDataW'($urandom_range(15));
      csr_write_enable <= 1'b1;
      csr_index <= CSR_WORD_LENGTH;
      csr_write_data <= word_length;
      @(posedge clock);
      csr_index <= CSR_MASK_LOWER;
      csr_write_data <= {noise[CsrDataW-1:1], mask_lower};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   task automatic random_traffic(input int beats);
      int               left;
      logic [KmerW-1:0] probe;
      for (left = beats; left > 0; left--) begin
         if (left == beats / 2) settle();
         if ($urandom_range(99) < 18) begin
            case ($urandom_range(2))
               0: probe = KmerW'($urandom_range(16'hFFFF));
               1: probe = recent_bases;
               default: probe = recent_bases >> 2;
            endcase
            send_query($urandom_range(9) == 0, probe);
         end else if (run_left == 0 || $urandom_range(99) < 4) begin
            run_left = $urandom_range(40, 1) - 1;
            run_noisy = ($urandom_range(4) == 0);
            run_lower = ($urandom_range(3) == 0);
            random_symbol(1'b1);
         end else begin
            run_left--;
            random_symbol(1'b0);
         end
      end
   endtask

   initial begin
      int               phase;
      int               i;
      logic [3:0]       word_length;
      logic             mask_lower;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (!req_ready) @(posedge clock);

      // k written as zero saturates to one, lowercase counts as bad
      set_config(4'd0, 1'b1);
      send_symbol(1'b1, 2'd0, 1'b0, 1'b0);
      send_symbol(1'b0, 2'd1, 1'b0, 1'b1);
      send_symbol(1'b0, 2'd1, 1'b0, 1'b0);
      send_symbol(1'b0, 2'd2, 1'b1, 1'b0);
      send_symbol(1'b0, 2'd2, 1'b0, 1'b0);
      send_symbol(1'b0, 2'd3, 1'b0, 1'b0);
      send_symbol(1'b0, 2'd3, 1'b0, 1'b0);
      send_query(1'b1, 16'hFFFF);
      send_query(1'b0, 16'hFFFC);
      send_query(1'b1, 16'h0000);
      settle();

      // k above the maximum saturates, lowercase is harmless
      set_config(4'd9, 1'b0);
      for (i = 0; i < 8; i++) send_symbol(i == 0, 2'd3, 1'b0, i[0]);
      send_symbol(1'b0, 2'd0, 1'b0, 1'b0);
      send_symbol(1'b0, 2'd0, 1'b1, 1'b0);
      send_query(1'b1, 16'hFFFF);
      send_query(1'b0, 16'h0000);
      settle();

      // shrink k in the middle of a sequence
      set_config(4'd2, 1'b1);
      send_symbol(1'b0, 2'd1, 1'b0, 1'b0);
      send_symbol(1'b0, 2'd1, 1'b0, 1'b0);

      for (phase = 0; phase < 10; phase++) begin
         settle();
         case (phase)
            0: word_length = 4'd15;
            1: word_length = 4'd1;
            2: word_length = 4'd8;
            3: word_length = 4'd4;
            default: word_length = 4'($urandom_range(15));
         endcase
         mask_lower = (phase < 4) ? phase[0] : 1'($urandom_range(1));
         set_config(word_length, mask_lower);
         sender_gaps = (phase != 3);
         receiver_stalls = (phase != 3);
         random_traffic(50);
      end
      settle();

      $display("run covered %0d beats over %0d sequence starts and %0d register settings,",
               beats_sent, sequence_starts, settings_used);
      $display("with %0d result beats checked, one stretch free of gaps and stalls",
               results_checked);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/kubf_pkg.sv
design/kubf_ctrl.sv
design/kubf_datapath.sv
design/kmer_unique_bitmap_filter.sv
tb/sv/kubf_checker.sv
tb/sv/tb_top.sv
